>>> rtl/core/isld_pkg.sv
// Package for the IEC 61131-3 string literal decoder.
// Holds the shared item and result types, character constants and the hex digit helpers.
// No dependencies; the design files use it by scoped names and the testbench imports it.
package isld_pkg;

  // Character constants used by the escape decoder.
  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_SQUOTE = 8'h27;  // single quote
  localparam logic [7:0] CH_DQUOTE = 8'h22;  // double quote
  localparam logic [7:0] CH_L      = 8'h6C;  // 'l'
  localparam logic [7:0] CH_N      = 8'h6E;  // 'n'
  localparam logic [7:0] CH_P      = 8'h70;  // 'p'
  localparam logic [7:0] CH_R      = 8'h72;  // 'r'
  localparam logic [7:0] CH_T      = 8'h74;  // 't'
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_FORMFEED  = 8'd12;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_TAB       = 8'd9;

  // Widths of the stream fields.
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;

  // Status reported on the end item.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_SHORT = 2'd1,
    ST_MISMATCH  = 2'd2,
    ST_BAD_ESC   = 2'd3
  } status_t;

  // One raw input item.
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              is_last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_string;
    status_t           status;
  } res_t;

  // True for 0-9, a-f and A-F.
  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Value of a hex digit; letters have a low nibble of 1 to 6, so adding nine gives 10 to 15.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    if (c[6]) begin
      hex_val = c[3:0] + 4'd9;
    end else begin
      hex_val = c[3:0];
    end
  endfunction

endpackage

>>> rtl/core/isld_in_stage.sv
// Input register stage of the string literal decoder.
// Depends on isld_pkg for the input item type.
// Takes one item per cycle while the output side has room, and hands it on when the decode stage advances.
module isld_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  isld_pkg::in_item_t in_item,
  input  logic               down_ready,
  output logic               item_valid,
  output logic               advance,
  output isld_pkg::in_item_t item
);

  logic held;

  // The held item moves on whenever the output side can take its result.
  assign advance    = held && down_ready;
  assign in_ready   = !held || down_ready;
  assign item_valid = held;

  // Valid flag and payload register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

>>> rtl/core/isld_decode.sv
// Decode stage of the string literal decoder: literal state and escape decoding.
// Depends on isld_pkg for the item and result types and the character helpers.
// Updates its state once for every item that advances and flags whether a result follows.
module isld_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  isld_pkg::in_item_t item,
  output logic               res_valid,
  output isld_pkg::res_t     res
);

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2
  } esc_mode_t;

  logic       awaiting_open, awaiting_open_next;
  logic [7:0] open_quote, open_quote_next;
  esc_mode_t  escape_mode, escape_mode_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       escape_error, escape_error_next;
  logic [7:0] c;

  assign c = item.in_byte;

  // Next state and result for the item in the input register.
  always_comb begin
    awaiting_open_next = awaiting_open;
    open_quote_next    = open_quote;
    escape_mode_next   = escape_mode;
    high_nibble_next   = high_nibble;
    escape_error_next  = escape_error;
    res_valid          = 1'b0;
    res                = '0;

    if (awaiting_open) begin
      if (item.is_last) begin
        // A one-byte literal closes at once.
        res_valid         = 1'b1;
        res.end_of_string = 1'b1;
        res.status        = isld_pkg::ST_TOO_SHORT;
        open_quote_next   = '0;
        high_nibble_next  = '0;
        escape_mode_next  = MODE_PLAIN;
        escape_error_next = 1'b0;
      end else begin
        open_quote_next    = c;
        awaiting_open_next = 1'b0;
        escape_mode_next   = MODE_PLAIN;
        escape_error_next  = 1'b0;
      end
    end else if (item.is_last) begin
      // Closing byte: report status in order of precedence, then return to reset state.
      res_valid         = 1'b1;
      res.end_of_string = 1'b1;
      if (!((open_quote == isld_pkg::CH_SQUOTE || open_quote == isld_pkg::CH_DQUOTE) &&
            c == open_quote)) begin
        res.status = isld_pkg::ST_MISMATCH;
      end else if (escape_error || escape_mode == MODE_ESC || escape_mode == MODE_HEX) begin
        res.status = isld_pkg::ST_BAD_ESC;
      end else begin
        res.status = isld_pkg::ST_OK;
      end
      awaiting_open_next = 1'b1;
      open_quote_next    = '0;
      escape_mode_next   = MODE_PLAIN;
      high_nibble_next   = '0;
      escape_error_next  = 1'b0;
    end else if (!escape_error) begin
      case (escape_mode)
        MODE_ESC: begin
          escape_mode_next = MODE_PLAIN;
          res_valid        = 1'b1;
          case (c)
            isld_pkg::CH_DOLLAR: res.out_byte = isld_pkg::CH_DOLLAR;
            isld_pkg::CH_SQUOTE: res.out_byte = isld_pkg::CH_SQUOTE;
            isld_pkg::CH_DQUOTE: res.out_byte = isld_pkg::CH_DQUOTE;
            isld_pkg::CH_L:      res.out_byte = isld_pkg::CH_NEWLINE;
            isld_pkg::CH_N:      res.out_byte = isld_pkg::CH_NEWLINE;
            isld_pkg::CH_P:      res.out_byte = isld_pkg::CH_FORMFEED;
            isld_pkg::CH_R:      res.out_byte = isld_pkg::CH_RETURN;
            isld_pkg::CH_T:      res.out_byte = isld_pkg::CH_TAB;
            default: begin
              res_valid = 1'b0;
              if (isld_pkg::is_hex(c)) begin
                high_nibble_next = isld_pkg::hex_val(c);
                escape_mode_next = MODE_HEX;
              end else begin
                escape_error_next = 1'b1;
              end
            end
          endcase
        end
        MODE_HEX: begin
          escape_mode_next = MODE_PLAIN;
          if (isld_pkg::is_hex(c)) begin
            res_valid    = 1'b1;
            res.out_byte = {high_nibble, isld_pkg::hex_val(c)};
          end else begin
            escape_error_next = 1'b1;
          end
        end
        default: begin
          // Plain text; the unused mode code is treated the same way.
          escape_mode_next = MODE_PLAIN;
          if (c == isld_pkg::CH_DOLLAR) begin
            escape_mode_next = MODE_ESC;
          end else begin
            res_valid    = 1'b1;
            res.out_byte = c;
          end
        end
      endcase
    end
  end

  // Literal state, updated once per advancing item.
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_open <= 1'b1;
      open_quote    <= '0;
      escape_mode   <= MODE_PLAIN;
      high_nibble   <= '0;
      escape_error  <= 1'b0;
    end else if (step) begin
      awaiting_open <= awaiting_open_next;
      open_quote    <= open_quote_next;
      escape_mode   <= escape_mode_next;
      high_nibble   <= high_nibble_next;
      escape_error  <= escape_error_next;
    end
  end

endmodule

>>> rtl/core/isld_out_stage.sv
// Output register stage of the string literal decoder.
// Depends on isld_pkg for the result type.
// Holds one result item until the downstream side takes it.
module isld_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  isld_pkg::res_t res_in,
  output logic           up_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output isld_pkg::res_t res_out
);

  // Room for a new result when empty or when the held one leaves this cycle.
  assign up_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= push;
    end
    if (push && up_ready) begin
      res_out <= res_in;
    end
  end

endmodule

>>> rtl/core/iec_string_literal_decoder.sv
// Channel  | Dir | Handshake                | Payload
// s_axis   | in  | s_tvalid / s_tready      | s_tdata = in_byte, s_tlast = is_last
// m_axis   | out | m_tvalid / m_tready      | m_tdata = out_byte, m_tlast = end_of_string,
//          |     |                          | m_tuser = status
//
// One byte is accepted per cycle while the output register has room; a result passes through the
// input register and then the output register before it is presented. Each register holds one item,
// and the literal state is updated in the single decode step between them.
// Reset returns the block to waiting for an opening quote with both registers empty.
// A stall on m_tready backs up through the output register to s_tready in the same cycle.
//
// Top level of the IEC 61131-3 string literal decoder; depends on isld_pkg,
// isld_in_stage, isld_decode and isld_out_stage.
module iec_string_literal_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [isld_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] in_byte
  input  logic                          s_tlast,   // is_last
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [isld_pkg::BYTE_W-1:0]   m_tdata,   // [7:0] out_byte
  output logic                          m_tlast,   // end_of_string
  output logic [isld_pkg::STATUS_W-1:0] m_tuser    // [1:0] status
);

  isld_pkg::in_item_t in_item;
  isld_pkg::in_item_t item;
  isld_pkg::res_t     res;
  isld_pkg::res_t     res_out;
  logic               item_valid;
  logic               advance;
  logic               res_valid;
  logic               out_room;

  assign in_item.in_byte = s_tdata;
  assign in_item.is_last = s_tlast;

  // Input register.
  isld_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .down_ready (out_room),
    .item_valid (item_valid),
    .advance    (advance),
    .item       (item)
  );

  // Decode step and literal state.
  isld_decode u_dec (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register.
  isld_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (item_valid && res_valid),
    .res_in    (res),
    .up_ready  (out_room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res_out   (res_out)
  );

  assign m_tdata = res_out.out_byte;
  assign m_tlast = res_out.end_of_string;
  assign m_tuser = res_out.status;

endmodule

>>> rtl/core/isld_checker.sv
// Port-level checks for the IEC 61131-3 string literal decoder.
// Depends on isld_pkg for the status codes; bound to iec_string_literal_decoder below.
module isld_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [isld_pkg::BYTE_W-1:0]   s_tdata,
  input logic                          s_tlast,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [isld_pkg::BYTE_W-1:0]   m_tdata,
  input logic                          m_tlast,
  input logic [isld_pkg::STATUS_W-1:0] m_tuser
);

  // An offered input item is held until it is accepted.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
    else $error("input item changed while waiting");

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
    $stable(m_tuser))
    else $error("result item changed while stalled");

  // Body bytes carry a clear status.
  a_body_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == isld_pkg::ST_OK)
    else $error("body item with nonzero status");

  // The end item carries a zero byte.
  a_end_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == '0)
    else $error("end item with nonzero byte");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result item valid after reset");

endmodule

bind iec_string_literal_decoder isld_checker u_isld_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for the IEC 61131-3 string literal decoder.
// It streams quoted literals in, predicts each decoded byte and end status, and checks them.
// Depends on isld_pkg and iec_string_literal_decoder.
module tb;
  import isld_pkg::*;

  // Digit bounds for hex escapes.
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  // The single-character escapes that may follow a dollar sign.
  localparam logic [7:0] ESC_CHARS [8] = '{CH_DOLLAR, CH_SQUOTE, CH_DQUOTE, CH_L,
                                           CH_N, CH_P, CH_R, CH_T};

  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int END_SETTLE   = 10;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_DOLLAR,
    ESC_HEX
  } esc_state_t;

  function automatic bit is_hex_char(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LOWER_A && c <= CH_LOWER_F) ||
           (c >= CH_UPPER_A && c <= CH_UPPER_F);
  endfunction

  function automatic logic [3:0] hex_char_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return 4'(c - CH_ZERO);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      return 4'(c - CH_LOWER_A + 8'd10);
    end
    return 4'(c - CH_UPPER_A + 8'd10);
  endfunction

  // Tracks the literal being decoded and holds the results still owed by the block.
  class literal_scoreboard;
    bit         waiting_open = 1'b1;
    logic [7:0] quote_seen   = 8'h00;
    esc_state_t esc_state    = ESC_NONE;
    logic [3:0] nibble_hi    = 4'h0;
    bit         esc_bad      = 1'b0;
    res_t       decoded_q[$];
    int         failures     = 0;

    function void clear_literal();
      waiting_open = 1'b1;
      quote_seen   = 8'h00;
      esc_state    = ESC_NONE;
      nibble_hi    = 4'h0;
      esc_bad      = 1'b0;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    // Decodes one accepted item and queues the result it causes, if any.
    function void note_byte(logic [7:0] c, logic last);
      res_t r;
      bit   emit;
      emit = 1'b0;
      r = '{out_byte: 8'h00, end_of_string: 1'b0, status: ST_OK};
      if (waiting_open) begin
        if (last) begin
          r.end_of_string = 1'b1;
          r.status = ST_TOO_SHORT;
          emit = 1'b1;
          clear_literal();
        end else begin
          quote_seen   = c;
          waiting_open = 1'b0;
          esc_state    = ESC_NONE;
          esc_bad      = 1'b0;
        end
      end else if (last) begin
        // The closing quote is never body text; mismatch outranks a bad escape.
        r.end_of_string = 1'b1;
        if (!((quote_seen == CH_SQUOTE || quote_seen == CH_DQUOTE) && c == quote_seen)) begin
          r.status = ST_MISMATCH;
        end else if (esc_bad || esc_state != ESC_NONE) begin
          r.status = ST_BAD_ESC;
        end
        emit = 1'b1;
        clear_literal();
      end else if (!esc_bad) begin
        case (esc_state)
          ESC_DOLLAR: begin
            esc_state = ESC_NONE;
            case (c)
              CH_DOLLAR, CH_SQUOTE, CH_DQUOTE: begin
                r.out_byte = c;
                emit = 1'b1;
              end
              CH_L, CH_N: begin
                r.out_byte = CH_NEWLINE;
                emit = 1'b1;
              end
              CH_P: begin
                r.out_byte = CH_FORMFEED;
                emit = 1'b1;
              end
              CH_R: begin
                r.out_byte = CH_RETURN;
                emit = 1'b1;
              end
              CH_T: begin
                r.out_byte = CH_TAB;
                emit = 1'b1;
              end
              default: begin
                if (is_hex_char(c)) begin
                  nibble_hi = hex_char_value(c);
                  esc_state = ESC_HEX;
                end else begin
                  esc_bad = 1'b1;
                end
              end
            endcase
          end
          ESC_HEX: begin
            esc_state = ESC_NONE;
            if (is_hex_char(c)) begin
              r.out_byte = {nibble_hi, hex_char_value(c)};
              emit = 1'b1;
            end else begin
              esc_bad = 1'b1;
            end
          end
          default: begin
            if (c == CH_DOLLAR) begin
              esc_state = ESC_DOLLAR;
            end else begin
              r.out_byte = c;
              emit = 1'b1;
            end
          end
        endcase
      end
      if (emit) begin
        decoded_q.push_back(r);
      end
    endfunction

    // Compares one accepted result with the oldest one owed.
    function void check_result(logic [7:0] b, logic eos, logic [1:0] st);
      res_t want;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result: out_byte %h end_of_string %b status %0d",
                 $time, b, eos, st);
        failures++;
        return;
      end
      want = decoded_q.pop_front();
      if (b !== want.out_byte) begin
        $display("%0t: out_byte mismatch: expected %h, actual %h", $time, want.out_byte, b);
        failures++;
      end
      if (eos !== want.end_of_string) begin
        $display("%0t: end_of_string mismatch: expected %b, actual %b",
                 $time, want.end_of_string, eos);
        failures++;
      end
      if (st !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status, st);
        failures++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;  // [7:0] in_byte
  logic       s_tlast  = 1'b0;   // is_last
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tlast;           // end_of_string
  logic [1:0] m_tuser;           // [1:0] status

  literal_scoreboard sb = new();
  logic [7:0] lit_q[$];
  int         burst_left = 0;
  int         items_sent = 0;
  int         cycle_cnt  = 0;

  iec_string_literal_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver stalls follow the cycle count: free running, coin toss, long stalls, light stalls.
  // The same counter ends a run that hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    case (cycle_cnt[9:8])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(0, 1));
      2'd2: m_tready <= (cycle_cnt[2:0] == 3'd0);
      default: m_tready <= ($urandom_range(0, 3) != 0);
    endcase
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Both handshakes are observed at the clock edge, before any update of that edge lands.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata, m_tlast, m_tuser);
      end
      if (s_tvalid && s_tready) begin
        sb.note_byte(s_tdata, s_tlast);
      end
    end
  end

  // Offers one item and returns at the edge that accepts it; bursts are broken by random gaps.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    items_sent++;
  endtask

  // Holds the sender off until every owed result has arrived.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) begin
      return CH_ZERO + 8'(v);
    end
    return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(v - 10);
  endfunction

  // Appends one body token: a plain byte, a one-character escape or a hex escape.
  function automatic void push_token();
    int         pick;
    logic [7:0] ch;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      ch = 8'($urandom_range(0, 255));
      while (ch == CH_DOLLAR) ch = 8'($urandom_range(0, 255));
      lit_q.push_back(ch);
    end else if (pick < 78) begin
      lit_q.push_back(CH_DOLLAR);
      lit_q.push_back(ESC_CHARS[$urandom_range(0, 7)]);
    end else begin
      lit_q.push_back(CH_DOLLAR);
      lit_q.push_back(rand_hex_char());
      lit_q.push_back(rand_hex_char());
    end
  endfunction

  // Appends an invalid escape: an unknown escape character or a hex digit followed by a non-digit.
  function automatic void push_bad_escape();
    logic [7:0] ch;
    bit         after_digit;
    after_digit = 1'($urandom_range(0, 1));
    ch = 8'($urandom_range(0, 255));
    while (is_hex_char(ch) || (!after_digit && (ch inside {ESC_CHARS}))) begin
      ch = 8'($urandom_range(0, 255));
    end
    lit_q.push_back(CH_DOLLAR);
    if (after_digit) begin
      lit_q.push_back(rand_hex_char());
    end
    lit_q.push_back(ch);
  endfunction

  // Sends one literal; most are well formed, the rest are short, mismatched or badly escaped.
  task automatic send_literal();
    int         kind;
    int         n;
    int         err_at;
    logic [7:0] open_ch;
    logic [7:0] close_ch;
    kind = $urandom_range(0, 99);
    open_ch = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
    close_ch = open_ch;
    lit_q.delete();
    if (kind < 5) begin
      send_byte(($urandom_range(0, 1) ? open_ch : 8'($urandom_range(0, 255))), 1'b1);
      return;
    end
    if (kind < 9) begin
      open_ch = 8'($urandom_range(0, 255));
    end else if (kind < 14) begin
      close_ch = 8'($urandom_range(0, 255));
    end
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
    err_at = (kind >= 14 && kind < 24) ? $urandom_range(0, n) : -1;
    for (int i = 0; i <= n; i++) begin
      if (i == err_at) begin
        push_bad_escape();
      end
      if (i < n) begin
        push_token();
      end
    end
    // An escape left open when the closing quote arrives.
    if (kind >= 24 && kind < 30) begin
      lit_q.push_back(CH_DOLLAR);
      if ($urandom_range(0, 1)) begin
        lit_q.push_back(rand_hex_char());
      end
    end
    send_byte(open_ch, 1'b0);
    foreach (lit_q[i]) send_byte(lit_q[i], 1'b0);
    send_byte(close_ch, 1'b1);
  endtask

  initial begin
    logic [7:0] esc_lit [21];
    int         random_end;
    bit         drained_mid;
    esc_lit = '{CH_SQUOTE, CH_DOLLAR, CH_DOLLAR, CH_DOLLAR, CH_SQUOTE, CH_DOLLAR, CH_DQUOTE,
                CH_DOLLAR, CH_L, CH_DOLLAR, CH_N, CH_DOLLAR, CH_P, CH_DOLLAR, CH_R,
                CH_DOLLAR, CH_T, CH_DOLLAR, CH_LOWER_F, CH_UPPER_A, CH_SQUOTE};
    drained_mid = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part: every escape and both hex digit cases, a one-byte literal,
    // and a bad opening byte with the extreme byte values.
    foreach (esc_lit[i]) send_byte(esc_lit[i], (i == 20));
    send_byte(CH_DQUOTE, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CH_DQUOTE, 1'b1);
    drain_results();

    // Random part, with one pause halfway through until the block has caught up.
    random_end = items_sent + RANDOM_ITEMS;
    while (items_sent < random_end) begin
      send_literal();
      if (!drained_mid && items_sent > random_end - RANDOM_ITEMS / 2) begin
        drain_results();
        drained_mid = 1'b1;
      end
    end

    drain_results();
    repeat (END_SETTLE) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/isld_pkg.sv
rtl/core/isld_in_stage.sv
rtl/core/isld_decode.sv
rtl/core/isld_out_stage.sv
rtl/core/iec_string_literal_decoder.sv
rtl/core/isld_checker.sv
tb/tb.sv
